[sv/wkt_pkg.sv]
package wkt_pkg;

   // Number of entries the table holds.
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int KEY_W      = 64;
   localparam int MOVE_W     = 16;
   localparam int WEIGHT_W   = 16;
   localparam int SQUARE_W   = 6;
   localparam int TO_LSB     = 0;
   localparam int FROM_LSB   = 6;

   // Request operation codes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PROBE = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [KEY_W-1:0]    entry_key;
      logic [MOVE_W-1:0]   move_word;
      logic [WEIGHT_W-1:0] entry_weight;
   } req_type;

   typedef struct packed {
      logic                found;
      logic [SQUARE_W-1:0] from_square;
      logic [SQUARE_W-1:0] to_square;
      logic                load_dropped;
   } rsp_type;

   // One stored book entry, as it sits in a single memory word.
   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [WEIGHT_W-1:0] weight;
      logic [SQUARE_W-1:0] from_square;
      logic [SQUARE_W-1:0] to_square;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } wkt_state_type;

endpackage

[sv/wkt_ram.sv]
module wkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/weighted_key_table_best_match_top.sv]
// Channel   Direction  Ports                           Carries
// request   in         req_valid, req_ready, req_data  load one entry or probe by key
// response  out        rsp_valid, rsp_ready, rsp_data  found, squares, load dropped flag
//
// A load writes the entry at the accepting edge and loads its response into
// the output register. A probe reads the stored entries one per cycle from the
// single read port, compares each as it leaves the registered read, then waits
// in done for a free output; an empty table goes straight to the done state.
// Reset clears the entry count, the state machine and the output valid flag; the
// table is never cleared. A request is taken only in idle with the output free.
module weighted_key_table_best_match_top import wkt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   wkt_state_type       state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  rd_addr_ff, rd_addr_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                cmp_last_ff, cmp_last_in;
   logic [KEY_W-1:0]    probe_key_ff, probe_key_in;
   logic [WEIGHT_W-1:0] best_weight_ff, best_weight_in;
   logic [SQUARE_W-1:0] best_from_ff, best_from_in;
   logic [SQUARE_W-1:0] best_to_ff, best_to_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                out_free;
   logic                req_fire;
   logic [SQUARE_W-1:0] load_from;
   logic [SQUARE_W-1:0] load_to;
   logic                null_move;
   logic                table_full;
   logic                issue;
   logic [COUNT_W-1:0]  rd_next;
   logic                hit;

   logic                wr_en;
   entry_type           wr_entry;
   entry_type           rd_entry;
   logic [ENTRY_W-1:0]  rd_word;

   // The whole entry lives in one memory word, so a probe reads key, weight
   // and squares together with one access per cycle.
   wkt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (rd_addr_ff[ADDR_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry = entry_type'(rd_word);

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_valid && req_ready;

   // The move word already holds square indexes: file in the low three bits,
   // rank in the next three.
   assign load_from  = req_data.move_word[FROM_LSB +: SQUARE_W];
   assign load_to    = req_data.move_word[TO_LSB +: SQUARE_W];
   assign null_move  = (load_from == load_to);
   assign table_full = (count_ff == COUNT_W'(TABLE_DEPTH));

   assign wr_entry.key         = req_data.entry_key;
   assign wr_entry.weight      = req_data.entry_weight;
   assign wr_entry.from_square = load_from;
   assign wr_entry.to_square   = load_to;

   // Reads are issued while the scan pointer is below the count. Writes only
   // happen in idle, so a read never meets a write to the same entry.
   assign issue   = (state_ff == ST_SCAN) && (rd_addr_ff != count_ff);
   assign rd_next = rd_addr_ff + COUNT_W'(1);

   // A strictly greater weight is needed, so ties keep the earlier entry and
   // a weight of zero never wins against the initial best of zero.
   assign hit = cmp_valid_ff && (rd_entry.key == probe_key_ff) &&
                (rd_entry.weight > best_weight_ff);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rd_addr_in     = rd_addr_ff;
      cmp_valid_in   = 1'b0;
      cmp_last_in    = 1'b0;
      probe_key_in   = probe_key_ff;
      best_weight_in = best_weight_ff;
      best_from_in   = best_from_ff;
      best_to_in     = best_to_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      wr_en          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.operation == OP_LOAD) begin
                  wr_en                    = !null_move && !table_full;
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.found        = 1'b0;
                  rsp_data_in.from_square  = '0;
                  rsp_data_in.to_square    = '0;
                  rsp_data_in.load_dropped = !null_move && table_full;
                  if (!null_move && !table_full) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end else begin
                  probe_key_in   = req_data.entry_key;
                  best_weight_in = '0;
                  best_from_in   = '0;
                  best_to_in     = '0;
                  rd_addr_in     = '0;
                  state_in       = (count_ff == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_addr_in   = rd_next;
               cmp_valid_in = 1'b1;
               cmp_last_in  = (rd_next == count_ff);
            end
            if (hit) begin
               best_weight_in = rd_entry.weight;
               best_from_in   = rd_entry.from_square;
               best_to_in     = rd_entry.to_square;
            end
            if (cmp_valid_ff && cmp_last_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // A square of zero counts as no usable entry, as in the book format.
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = (best_from_ff != '0) && (best_to_ff != '0);
               rsp_data_in.from_square  = rsp_data_in.found ? best_from_ff : '0;
               rsp_data_in.to_square    = rsp_data_in.found ? best_to_ff : '0;
               rsp_data_in.load_dropped = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         cmp_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         cmp_last_ff  <= cmp_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      probe_key_ff   <= probe_key_in;
      best_weight_ff <= best_weight_in;
      best_from_ff   <= best_from_in;
      best_to_ff     <= best_to_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The entry count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   // Compare data only arrives while a scan is in progress.
   assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (state_ff == ST_SCAN))
      else $error("compare stage active outside a scan");

   // A stored load bumps the count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.operation == OP_LOAD && !null_move && !table_full)
      |=> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("stored load did not advance the entry count");

   // A found response always carries two nonzero squares and no drop flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.found) |->
      ((rsp_data_ff.from_square != '0) && (rsp_data_ff.to_square != '0) &&
       !rsp_data_ff.load_dropped))
      else $error("found response with a zero square or drop flag");

endmodule

[verif/wkt_best_match_checker.sv]
module wkt_best_match_checker import wkt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);

   // Private copy of the book: entries are appended in load order.
   logic [KEY_W-1:0]    book_key    [TABLE_DEPTH];
   logic [WEIGHT_W-1:0] book_weight [TABLE_DEPTH];
   logic [SQUARE_W-1:0] book_from   [TABLE_DEPTH];
   logic [SQUARE_W-1:0] book_to     [TABLE_DEPTH];
   int                  book_size;

   rsp_type             expected_rsp_q [$];

   // Applies one request to the book copy and returns the response it should give.
   function automatic rsp_type best_move_for(input req_type r);
      rsp_type             rsp;
      logic [SQUARE_W-1:0] src;
      logic [SQUARE_W-1:0] dst;
      logic [WEIGHT_W-1:0] best_weight;
      logic [SQUARE_W-1:0] best_from;
      logic [SQUARE_W-1:0] best_to;
      rsp = '0;
      if (r.operation == OP_LOAD) begin
         src = r.move_word[FROM_LSB +: SQUARE_W];
         dst = r.move_word[TO_LSB +: SQUARE_W];
         if (src != dst) begin
            if (book_size >= TABLE_DEPTH) begin
               rsp.load_dropped = 1'b1;
            end else begin
               book_key[book_size]    = r.entry_key;
               book_weight[book_size] = r.entry_weight;
               book_from[book_size]   = src;
               book_to[book_size]     = dst;
               book_size++;
            end
         end
      end else begin
         best_weight = '0;
         best_from   = '0;
         best_to     = '0;
         for (int i = 0; i < book_size; i++) begin
            if (book_key[i] == r.entry_key && book_weight[i] > best_weight) begin
               best_weight = book_weight[i];
               best_from   = book_from[i];
               best_to     = book_to[i];
            end
         end
         if (best_from != '0 && best_to != '0) begin
            rsp.found       = 1'b1;
            rsp.from_square = best_from;
            rsp.to_square   = best_to;
         end
      end
      return rsp;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         book_size   = 0;
         error_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("found", int'(want.found), int'(rsp_data.found));
               check_field("from_square", int'(want.from_square),
                           int'(rsp_data.from_square));
               check_field("to_square", int'(want.to_square), int'(rsp_data.to_square));
               check_field("load_dropped", int'(want.load_dropped),
                           int'(rsp_data.load_dropped));
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.insert(expected_rsp_q.size(), best_move_for(req_data));
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

[verif/tb_weighted_key_table_best_match_top.sv]
module tb_weighted_key_table_best_match_top import wkt_pkg::*;;

   localparam int KEY_POOL_SIZE  = 6;
   localparam int HOLDOFF_CYCLES = 3000;
   localparam int PHASE_ITEMS    = 135;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      error_count;
   int      pending_count;

   // Percentages that shape the idling of both sides in the current phase.
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;

   // Long receiver hold-off, armed once by the stimulus and timed by the receiver.
   logic    holdoff_armed = 1'b0;
   logic    holdoff_done  = 1'b0;

   // A handful of keys that most requests reuse, so that probes actually hit
   // entries and weights compete. Slot 0 is the all-zero key, slot 1 all ones.
   logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

   weighted_key_table_best_match_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The checker sees both channels exactly as the block does and keeps its own
   // copy of the book; it only reports how many errors and open responses it has.
   wkt_best_match_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Reset is held at the start of the run and never asserted again.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Receiver side. Each cycle it decides afresh whether to stall, except for
   // the one long hold-off, during which it keeps ready low so the output
   // register stays full and the block has to refuse further requests.
   initial begin
      forever begin
         @(posedge clock);
         if (holdoff_armed && !holdoff_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_done <= 1'b1;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Builds a request with its move word assembled from the two squares; the
   // top nibble of the move word is unused by the block and given separately.
   function automatic req_type make_request(input logic op, input logic [KEY_W-1:0] key,
                                            input int src, input int dst, input int weight,
                                            input logic [3:0] spare);
      req_type r;
      r.operation    = op;
      r.entry_key    = key;
      r.move_word    = {spare, src[SQUARE_W-1:0], dst[SQUARE_W-1:0]};
      r.entry_weight = weight[WEIGHT_W-1:0];
      return r;
   endfunction

   // Random request: mostly pooled keys, with some null moves, some moves that
   // touch square zero, and weights that are often zero, maximal or tied.
   function automatic req_type random_request(input int probe_pct);
      req_type r;
      int      pick;
      r.operation = ($urandom_range(99) < probe_pct) ? OP_PROBE : OP_LOAD;
      if ($urandom_range(99) < 75)
         r.entry_key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      else
         r.entry_key = {$urandom, $urandom};
      r.move_word = MOVE_W'($urandom_range(16'hFFFF));
      pick = $urandom_range(99);
      if (pick < 8)
         r.move_word[FROM_LSB +: SQUARE_W] = r.move_word[TO_LSB +: SQUARE_W];
      else if (pick < 14)
         r.move_word[FROM_LSB +: SQUARE_W] = '0;
      else if (pick < 20)
         r.move_word[TO_LSB +: SQUARE_W] = '0;
      pick = $urandom_range(99);
      if (pick < 20)
         r.entry_weight = '0;
      else if (pick < 30)
         r.entry_weight = '1;
      else if (pick < 45)
         r.entry_weight = WEIGHT_W'($urandom_range(4, 1));
      else
         r.entry_weight = WEIGHT_W'($urandom_range(16'hFFFF));
      return r;
   endfunction

   // Offers one request and holds it until the block takes it. After that the
   // sender may go idle for a while; if it does not, valid simply stays high
   // for the next request, so it is never dropped and raised in one step.
   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      repeat (PHASE_ITEMS) send_request(random_request(40));
   endtask

   initial begin
      logic [KEY_W-1:0] k0;
      logic [KEY_W-1:0] k1;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      k0 = key_pool[0];
      k1 = key_pool[1];

      while (reset) @(posedge clock);

      // Directed part. A probe on the empty table comes first; then ties on
      // weight where the earliest entry must win, the largest weight, weight
      // zero never counting, null moves being discarded, best entries with a
      // square of zero reading as not found, and the unused top bits of the
      // move word set.
      send_request(make_request(OP_PROBE, k0, 0, 0, 0, 4'h0));
      send_request(make_request(OP_LOAD, k0, 12, 28, 10, 4'h0));
      send_request(make_request(OP_LOAD, k0, 5, 7, 10, 4'hA));
      send_request(make_request(OP_PROBE, k0, 0, 0, 0, 4'h0));
      send_request(make_request(OP_LOAD, k0, 63, 62, 65535, 4'hF));
      send_request(make_request(OP_PROBE, k0, 63, 63, 65535, 4'hF));
      send_request(make_request(OP_LOAD, k1, 1, 2, 0, 4'h0));
      send_request(make_request(OP_PROBE, k1, 0, 0, 0, 4'h0));
      send_request(make_request(OP_LOAD, k1, 3, 3, 500, 4'h5));
      send_request(make_request(OP_PROBE, k1, 0, 0, 0, 4'h0));
      send_request(make_request(OP_LOAD, k1, 0, 9, 7, 4'h0));
      send_request(make_request(OP_PROBE, k1, 0, 0, 0, 4'h0));
      send_request(make_request(OP_LOAD, k1, 20, 0, 8, 4'h0));
      send_request(make_request(OP_PROBE, k1, 0, 0, 0, 4'h0));
      send_request(make_request(OP_LOAD, k1, 40, 41, 9, 4'h3));
      send_request(make_request(OP_PROBE, k1, 0, 0, 0, 4'h0));
      send_request(make_request(OP_LOAD, 64'h5555_5555_5555_5555, 62, 63, 1, 4'h0));
      send_request(make_request(OP_PROBE, 64'h5555_5555_5555_5555, 0, 0, 0, 4'h0));
      send_request(make_request(OP_PROBE, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 4'h0));
      send_request(make_request(OP_LOAD, k0, 63, 63, 100, 4'hF));
      send_request(make_request(OP_LOAD, k0, 0, 0, 100, 4'h0));
      send_request(make_request(OP_LOAD, k0, 10, 11, 65535, 4'h0));
      send_request(make_request(OP_PROBE, k0, 0, 0, 0, 4'h0));

      // Pressure: the receiver holds off for a long stretch while the sender
      // keeps offering loads back to back, so the output fills and the block stalls.
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      holdoff_armed <= 1'b1;
      repeat (20) send_request(random_request(0));

      // Random phases, each with its own idling pattern.
      run_random_phase(0, 0);
      run_random_phase(72, 0);
      run_random_phase(0, 72);
      run_random_phase(11, 11);

      // One more null move, which must be discarded without a drop flag.
      send_request(make_request(OP_LOAD, k1, 17, 17, 9, 4'h0));

      // Probes that scan every stored entry.
      for (int i = 0; i < 8; i++)
         send_request(make_request(OP_PROBE, key_pool[i % KEY_POOL_SIZE], 0, 0, 0, 4'h0));

      req_valid <= 1'b0;
      rsp_stall_pct <= 0;

      // Let every open response arrive, then give the block the length of a
      // full scan to show any response nobody asked for.
      while (pending_count != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);

      if (error_count == 0)
         $display("tb_weighted_key_table_best_match_top: done, clean");
      else
         $display("tb_weighted_key_table_best_match_top: done, errors");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #200_000_000;
      $display("tb_weighted_key_table_best_match_top: done, errors");
      $finish;
   end

endmodule
